>>> sv/anmi_pkg.sv
// shared constants and types for the adjacency matrix neighbor iterator
package anmi_pkg;

  localparam int MAX_NODES = 64;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int CFG_W     = 7;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  // item kind codes
  localparam logic KIND_EDGE  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef logic [MAX_NODES-1:0] row_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [NODE_W-1:0]    node_t;

  // classified item passed from front to back
  typedef struct packed {
    logic  kind;
    logic  in_range;
    node_t node;
    node_t target;
  } work_t;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } back_state_t;

endpackage

>>> sv/anmi_ifs.sv
// channel interfaces: input items, results and configuration writes
interface anmi_item_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [5:0] node;
  logic [5:0] target;
  modport source (output valid, output kind, output node, output target, input ready);
  modport sink   (input valid, input kind, input node, input target, output ready);
endinterface

interface anmi_result_if;
  logic       valid;
  logic       ready;
  logic [5:0] neighbor;
  logic       found;
  modport source (output valid, output neighbor, output found, input ready);
  modport sink   (input valid, input neighbor, input found, output ready);
endinterface

interface anmi_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] node_count;
  modport source (output valid, output node_count, input ready);
  modport sink   (input valid, input node_count, output ready);
endinterface

>>> sv/anmi_queue.sv
// two-entry queue between front and back
module anmi_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  anmi_pkg::work_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output anmi_pkg::work_t head
);
  import anmi_pkg::*;

  work_t             slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign full      = (fill == QCNT_W'(QDEPTH));
  assign not_empty = (fill != '0);
  assign head      = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

>>> sv/anmi_front.sv
// front end: node count register, range check and queue push
module anmi_front (
  input  logic            clk,
  input  logic            rst,
  anmi_item_if.sink       items,
  anmi_cfg_if.sink        cfg,
  input  logic            q_full,
  output logic            q_push,
  output anmi_pkg::work_t q_data,
  output anmi_pkg::cnt_t  count
);
  import anmi_pkg::*;

  logic [CFG_W-1:0] node_count;
  logic             node_ok;
  logic             target_ok;
  logic             in_range;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= CFG_W'(MAX_NODES);
    end else if (cfg.valid && cfg.ready) begin
      node_count <= cfg.node_count;
    end
  end

  assign cfg.ready = 1'b1;

  // saturate to the matrix size
  assign count = (node_count > CFG_W'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                  : CNT_W'(node_count);

  // classify the incoming item
  assign node_ok   = (CNT_W'(items.node) < count);
  assign target_ok = (CNT_W'(items.target) < count);
  assign in_range  = (items.kind == KIND_EDGE) ? (node_ok && target_ok) : node_ok;

  assign items.ready = !q_full;

  // out of range edges are taken and dropped here
  assign q_push = items.valid && !q_full && (in_range || items.kind == KIND_QUERY);

  assign q_data.kind     = items.kind;
  assign q_data.in_range = in_range;
  assign q_data.node     = NODE_W'(items.node);
  assign q_data.target   = NODE_W'(items.target);

endmodule

>>> sv/anmi_back.sv
// back end: row and cursor memories, next-neighbor scan and result register
module anmi_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  anmi_pkg::work_t q_head,
  output logic            q_pop,
  input  anmi_pkg::cnt_t  count,
  anmi_result_if.source   results
);
  import anmi_pkg::*;

  back_state_t state;
  back_state_t state_next;

  // memories, rows valid-tracked so reset reads as zero
  row_t rows    [MAX_NODES];
  cnt_t cursors [MAX_NODES];
  logic [MAX_NODES-1:0] row_valid;
  logic [MAX_NODES-1:0] cur_valid;
  logic [MAX_NODES-1:0] exhausted;

  // item under execution and its read data
  work_t cur_item;
  row_t  row_rd;
  logic  row_ok;
  cnt_t  cur_rd;
  logic  cur_ok;
  logic  exh_rd;

  logic  res_valid;
  node_t res_neighbor;
  logic  res_found;

  row_t  row_eff;
  cnt_t  cursor_eff;
  row_t  hits;
  logic  hit_any;
  node_t hit_idx;
  logic  out_free;
  logic  go;
  logic  do_edge;
  logic  do_query;
  logic  do_scan;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (q_valid) state_next = BK_EXEC;
      BK_EXEC: if (go) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop    = 1'b0;
    do_edge  = 1'b0;
    do_query = 1'b0;
    unique case (state)
      BK_IDLE: q_pop = q_valid;
      BK_EXEC: begin
        do_edge  = go && (cur_item.kind == KIND_EDGE);
        do_query = go && (cur_item.kind == KIND_QUERY);
      end
      default: q_pop = 1'b0;
    endcase
  end

  assign out_free = !res_valid || results.ready;
  assign go       = (cur_item.kind == KIND_EDGE) || out_free;
  assign do_scan  = do_query && cur_item.in_range && !exh_rd;

  // memory read for the item being popped
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_item <= q_head;
      row_rd   <= rows[q_head.node];
      cur_rd   <= cursors[q_head.node];
    end
  end

  // valid bits sampled together with the read
  always_ff @(posedge clk) begin
    if (rst) begin
      row_ok <= 1'b0;
      cur_ok <= 1'b0;
      exh_rd <= 1'b0;
    end else if (q_pop) begin
      row_ok <= row_valid[q_head.node];
      cur_ok <= cur_valid[q_head.node];
      exh_rd <= exhausted[q_head.node];
    end
  end

  assign row_eff    = row_ok ? row_rd : '0;
  assign cursor_eff = cur_ok ? cur_rd : '0;

  // columns from cursor up to the node count
  always_comb begin
    for (int c = 0; c < MAX_NODES; c++) begin
      hits[c] = row_eff[c] && (CNT_W'(c) >= cursor_eff) && (CNT_W'(c) < count);
    end
  end

  // lowest set column
  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int c = MAX_NODES - 1; c >= 0; c--) begin
      if (hits[c]) begin
        hit_any = 1'b1;
        hit_idx = NODE_W'(c);
      end
    end
  end

  // memory write back
  always_ff @(posedge clk) begin
    if (do_edge) begin
      rows[cur_item.node] <= row_eff | (row_t'(1) << cur_item.target);
    end
    if (do_scan) begin
      cursors[cur_item.node] <= hit_any ? CNT_W'(hit_idx) + 1'b1 : '0;
    end
  end

  // per-node flags
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      cur_valid <= '0;
      exhausted <= '0;
    end else begin
      if (do_edge) begin
        row_valid[cur_item.node] <= 1'b1;
      end
      if (do_scan) begin
        cur_valid[cur_item.node] <= 1'b1;
        if (!hit_any) begin
          exhausted[cur_item.node] <= 1'b1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (do_query) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_query) begin
      res_found    <= do_scan && hit_any;
      res_neighbor <= (do_scan && hit_any) ? hit_idx : '0;
    end
  end

  assign results.valid    = res_valid;
  assign results.neighbor = 6'(res_neighbor);
  assign results.found    = res_found;

endmodule

>>> sv/adjacency_matrix_neighbor_iterator.sv
// Directed adjacency bit matrix with a per-node next-neighbor cursor.
//
// Channels: items (kind, node, target) in, results (neighbor, found) out,
// cfg writes the node count. All use valid/ready; a transaction completes
// on a rising edge with both high. cfg is always ready and should only be
// written while the block is idle.
// An add-edge item sets one matrix bit and gives no result. A query item
// gives exactly one result: the next set column from the node's cursor,
// or not found once the row is used up (the node then stays exhausted).
// The back end takes one item at a time: it does a row and cursor read,
// then a scan and write back, on single-port memories, before it pops
// the next item. Query results leave from a registered output.
// A two-entry queue sits between the range-check front and the back end,
// so items are still taken while a result waits in the output register.
// When results stalls, the queue fills and items.ready drops.
// Reset (synchronous, rst high) clears the matrix, cursors and exhausted
// flags at once through per-row valid bits; no clearing pass. The node
// count resets to 64.
module adjacency_matrix_neighbor_iterator (
  input  logic          clk,
  input  logic          rst,
  anmi_item_if.sink     items,
  anmi_cfg_if.sink      cfg,
  anmi_result_if.source results
);
  import anmi_pkg::*;

  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_valid;
  work_t q_data;
  work_t q_head;
  cnt_t  count;

  // range check and configuration
  anmi_front u_front (
    .clk    (clk),
    .rst    (rst),
    .items  (items),
    .cfg    (cfg),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_data),
    .count  (count)
  );

  // decoupling queue
  anmi_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  // execution
  anmi_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .count   (count),
    .results (results)
  );

endmodule
